[hdl/rcd_pkg.sv]
// rcd_pkg: shared constants, register and request codes, and the close control
// struct for the rc discharge sensor array
// no dependencies
package rcd_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int TIME_WIDTH_DEF   = 16;

  localparam int PIN_W      = 16;
  localparam int CH_W       = 4;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int COUNT_W    = 5;
  localparam int READS_W    = 10;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_MODE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_READS = 2'd3;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_START = 1'b1;

  localparam logic [VAL_W-1:0]   TIMEOUT_RST     = 16'd2500;
  localparam logic [COUNT_W-1:0] CHANNELS_RST    = 5'd8;
  localparam logic [READS_W-1:0] CALIB_READS_RST = 10'd10;

  // per-lane control for the steps after a reading closes
  typedef struct packed {
    logic snap;      // take the capture time, widen min/max
    logic calib;     // calibration round in progress
    logic first;     // first reading of the round loads min/max
    logic thr_load;  // round complete, thresholds take the midpoint
  } close_ctl_t;

endpackage

[hdl/rcd_ifs.sv]
// rcd item, result and configuration channel interfaces
// depends on rcd_pkg
interface rcd_item_if;
  import rcd_pkg::*;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [PIN_W-1:0] pin_levels;
  modport source (output valid, req_type, pin_levels, input ready);
  modport sink (input valid, req_type, pin_levels, output ready);
endinterface

interface rcd_result_if;
  import rcd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  channel;
  logic [VAL_W-1:0] discharge_time;
  logic             is_white;
  logic [VAL_W-1:0] threshold_value;
  logic [VAL_W-1:0] min_seen;
  logic [VAL_W-1:0] max_seen;
  logic [VAL_W-1:0] sensor_bits;
  logic             last;
  modport source (output valid, channel, discharge_time, is_white, threshold_value,
                  min_seen, max_seen, sensor_bits, last, input ready);
  modport sink (input valid, channel, discharge_time, is_white, threshold_value,
                min_seen, max_seen, sensor_bits, last, output ready);
endinterface

interface rcd_cfg_if;
  import rcd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/rcd_lane.sv]
// rcd_lane: one sensor channel; discharge capture, calibration min/max and
// threshold, white classification
// depends on rcd_pkg (close_ctl_t)
module rcd_lane #(
  parameter int TIME_WIDTH = rcd_pkg::TIME_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   tick,
  input  logic                   pin,
  input  logic                   active,
  input  logic [TIME_WIDTH-1:0]  elapsed,
  input  logic [TIME_WIDTH-1:0]  timeout,
  input  rcd_pkg::close_ctl_t    ctl,
  output logic [TIME_WIDTH-1:0]  snap_time,
  output logic [TIME_WIDTH-1:0]  threshold,
  output logic [TIME_WIDTH-1:0]  cal_min,
  output logic [TIME_WIDTH-1:0]  cal_max,
  output logic                   white
);

  logic [TIME_WIDTH-1:0] capture;
  logic [TIME_WIDTH:0]   mid_sum;

  assign mid_sum = {1'b0, cal_min} + {1'b0, cal_max};
  assign white   = snap_time < threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      capture   <= '0;
      snap_time <= '0;
      threshold <= '0;
      cal_min   <= '0;
      cal_max   <= '0;
    end else begin
      if (start) begin
        capture <= timeout;
      end else if (tick && !pin && capture > elapsed) begin
        capture <= elapsed;
      end
      // snapshot so a new reading can start while the burst drains
      if (ctl.snap) begin
        snap_time <= capture;
        if (ctl.calib && active) begin
          if (ctl.first || capture > cal_max) cal_max <= capture;
          if (ctl.first || capture < cal_min) cal_min <= capture;
        end
      end
      if (ctl.thr_load && active) begin
        threshold <= mid_sum[TIME_WIDTH:1];
      end
    end
  end

endmodule

[hdl/rcd_merge.sv]
// rcd_merge: packs the lanes' white bits and walks the active lanes, one
// result transfer per cycle unless result stalls, through a registered output stage
// depends on rcd_pkg and rcd_result_if
module rcd_merge #(
  parameter int MAX_CHANNELS = rcd_pkg::MAX_CHANNELS_DEF,
  parameter int TIME_WIDTH   = rcd_pkg::TIME_WIDTH_DEF,
  parameter int NW           = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   load,
  input  logic [NW-1:0]                          n_act,
  input  logic [MAX_CHANNELS-1:0]                act_vec,
  input  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] snap_time,
  input  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] threshold,
  input  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] cal_min,
  input  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] cal_max,
  input  logic [MAX_CHANNELS-1:0]                white_vec,
  output logic                                   busy,
  rcd_result_if.source                           result
);
  import rcd_pkg::*;

  localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [IW-1:0]           idx;
  logic [MAX_CHANNELS-1:0] bits;
  logic                    advance;
  logic                    last_hit;

  assign advance  = busy && (!result.valid || result.ready);
  assign last_hit = (NW'(idx) + NW'(1)) == n_act;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      idx          <= '0;
      bits         <= '0;
      result.valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        idx  <= '0;
        bits <= white_vec & act_vec;
      end else if (advance) begin
        idx <= idx + IW'(1);
        if (last_hit) busy <= 1'b0;
      end
      if (advance) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.channel         <= CH_W'(idx);
      result.discharge_time  <= VAL_W'(snap_time[idx]);
      result.is_white        <= bits[idx];
      result.threshold_value <= VAL_W'(threshold[idx]);
      result.min_seen        <= VAL_W'(cal_min[idx]);
      result.max_seen        <= VAL_W'(cal_max[idx]);
      result.sensor_bits     <= VAL_W'(bits);
      result.last            <= last_hit;
    end
  end

endmodule

[hdl/rc_discharge_sensor_array_top.sv]
// rc_discharge_sensor_array_top: takes one item per cycle (start or tick), all
// channels sampled in parallel lanes. A closing tick runs close steps s1, s2, s3,
// then one result per cycle, unless result stalls, for each active channel. ready
// drops, for any item, while the next tick would close a reading and the
// previous burst is still being formed or drained. Synchronous reset clears all
// control and every per-channel store; configuration returns to its reset values.
module rc_discharge_sensor_array_top #(
  parameter int MAX_CHANNELS = rcd_pkg::MAX_CHANNELS_DEF,
  parameter int TIME_WIDTH   = rcd_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rcd_item_if.sink      item,
  rcd_result_if.source  result,
  rcd_cfg_if.sink       cfg
);
  import rcd_pkg::*;

  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

  logic [VAL_W-1:0]   timeout_ticks;
  logic [COUNT_W-1:0] channel_count;
  logic               calib_mode;
  logic [READS_W-1:0] calib_reads;

  logic [TIME_WIDTH-1:0] elapsed;
  logic [TIME_WIDTH-1:0] elapsed_inc;
  logic [TIME_WIDTH-1:0] timeout_m;
  logic                  reading_active;
  logic                  will_close;
  logic                  pipe_busy;
  logic                  burst_busy;
  logic                  item_fire;
  logic                  start_fire;
  logic                  tick_fire;
  logic                  close_evt;
  logic                  s1;
  logic                  s2;
  logic                  s3;
  logic                  calib_act;
  logic                  thr_update;
  logic                  round_done;
  logic [READS_W-1:0]    calib_index;
  logic [READS_W-1:0]    calib_inc;
  logic [READS_W-1:0]    reads_eff;
  logic [NW-1:0]         n_eff;
  logic [NW-1:0]         n_act;
  logic [MAX_CHANNELS-1:0] cur_vec;
  logic [MAX_CHANNELS-1:0] act_vec;
  logic [MAX_CHANNELS-1:0] white_vec;
  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] snap_time;
  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] threshold;
  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] cal_min;
  logic [MAX_CHANNELS-1:0][TIME_WIDTH-1:0] cal_max;
  close_ctl_t            ctl;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      channel_count <= CHANNELS_RST;
      calib_mode    <= 1'b0;
      calib_reads   <= CALIB_READS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_TIMEOUT:     timeout_ticks <= cfg.data;
        REG_CHANNELS:    channel_count <= cfg.data[COUNT_W-1:0];
        REG_CALIB_MODE:  calib_mode    <= cfg.data[0];
        REG_CALIB_READS: calib_reads   <= cfg.data[READS_W-1:0];
        default: ;
      endcase
    end
  end

  // channel count clamped to 1..MAX_CHANNELS
  always_comb begin
    if (channel_count == '0) begin
      n_eff = NW'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      n_eff = NW'(MAX_CHANNELS);
    end else begin
      n_eff = NW'(channel_count);
    end
  end

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_vec
    assign cur_vec[i] = int'(n_eff) > i;
    assign act_vec[i] = int'(n_act) > i;
  end

  // reading control
  assign timeout_m   = TIME_WIDTH'(timeout_ticks);
  assign elapsed_inc = (elapsed < TIME_MAX) ? elapsed + TIME_WIDTH'(1) : elapsed;
  assign will_close  = reading_active && (elapsed_inc >= timeout_m);
  assign pipe_busy   = s1 || s2 || s3 || burst_busy;
  assign item.ready  = !(will_close && pipe_busy);

  assign item_fire  = item.valid && item.ready;
  assign start_fire = item_fire && (item.req_type == REQ_START);
  assign tick_fire  = item_fire && (item.req_type == REQ_TICK) && reading_active;
  assign close_evt  = tick_fire && will_close;

  assign calib_inc  = calib_index + READS_W'(1);
  assign reads_eff  = (calib_reads == '0) ? READS_W'(1) : calib_reads;
  assign round_done = calib_inc >= reads_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed        <= '0;
      reading_active <= 1'b0;
      s1             <= 1'b0;
      s2             <= 1'b0;
      s3             <= 1'b0;
      n_act          <= NW'(1);
      calib_act      <= 1'b0;
      thr_update     <= 1'b0;
      calib_index    <= '0;
    end else begin
      if (start_fire) begin
        elapsed        <= '0;
        reading_active <= 1'b1;
      end else if (tick_fire) begin
        elapsed <= elapsed_inc;
        if (will_close) reading_active <= 1'b0;
      end
      s1 <= close_evt;
      s2 <= s1;
      s3 <= s2;
      if (close_evt) begin
        n_act     <= n_eff;
        calib_act <= calib_mode;
      end
      if (s1) begin
        thr_update <= calib_act && round_done;
        if (calib_act) calib_index <= round_done ? '0 : calib_inc;
      end
    end
  end

  assign ctl.snap     = s1;
  assign ctl.calib    = calib_act;
  assign ctl.first    = calib_index == '0;
  assign ctl.thr_load = s2 && thr_update;

  for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_lane
    rcd_lane #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .start     (start_fire),
      .tick      (tick_fire && cur_vec[i]),
      .pin       (item.pin_levels[i]),
      .active    (act_vec[i]),
      .elapsed   (elapsed),
      .timeout   (timeout_m),
      .ctl       (ctl),
      .snap_time (snap_time[i]),
      .threshold (threshold[i]),
      .cal_min   (cal_min[i]),
      .cal_max   (cal_max[i]),
      .white     (white_vec[i])
    );
  end

  rcd_merge #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .TIME_WIDTH  (TIME_WIDTH),
    .NW          (NW)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (s3),
    .n_act     (n_act),
    .act_vec   (act_vec),
    .snap_time (snap_time),
    .threshold (threshold),
    .cal_min   (cal_min),
    .cal_max   (cal_max),
    .white_vec (white_vec),
    .busy      (burst_busy),
    .result    (result)
  );

  // close steps and burst never overlap
  a_close_serial: assert property (@(posedge clk) disable iff (rst)
    $onehot0({s1, s2, s3, burst_busy}))
    else $error("close pipeline overlap");

  // a closing tick ends the reading and starts the close steps
  a_close_ends: assert property (@(posedge clk) disable iff (rst)
    close_evt |=> (!reading_active && s1))
    else $error("reading still open after close");

  // results only appear while a burst is being walked
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(burst_busy))
    else $error("result without burst");

endmodule
